>>> src/stopping_point_projector_defines.svh
// Assertion macros for the stopping point projector checker.
`ifndef STOPPING_POINT_PROJECTOR_DEFINES_SVH
`define STOPPING_POINT_PROJECTOR_DEFINES_SVH

// Clocked check, off while reset is active.
`define SPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SPP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/spp_pkg.sv
// Types, widths and constants shared by the stopping point projector.
`timescale 1ns / 1ps
`default_nettype none

package spp_pkg;

  localparam int POS_W   = 32;
  localparam int VEL_W   = 24;
  localparam int QUAT_W  = 16;
  localparam int DEC_W   = 24;
  localparam int C_W     = 41;                // q x v
  localparam int P2_W    = 57;                // q * (q x v)
  localparam int ACC_W   = 59;                // rotated velocity, Q.44
  localparam int FRAC_SH = 28;                // Q.44 -> Q.16
  localparam int R_W     = 31;                // rotated velocity, Q.16 signed
  localparam int RMAG_W  = 30;
  localparam int SUMSQ_W = 62;
  localparam int ROOT_W  = SUMSQ_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int DIVD_W  = 62;
  localparam int DEN_W   = DEC_W + 1;
  localparam int SUM_W   = 64;

  localparam logic [SUMSQ_W-1:0] SLOW_SUMSQ_MAX = SUMSQ_W'(4294);
  localparam logic signed [SUM_W-1:0] POS_MAX_S = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] POS_MIN_S = -SUM_W'(64'sd2147483648);

  typedef enum logic [1:0] {
    OUT_PROJECTED = 2'd0,
    OUT_BAD_DECEL = 2'd1,
    OUT_TOO_SLOW  = 2'd2,
    OUT_SATURATED = 2'd3
  } outcome_e;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [VEL_W-1:0]  vel_fwd;
    logic signed [VEL_W-1:0]  vel_side;
    logic signed [VEL_W-1:0]  vel_up;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] stop_x;
    logic signed [POS_W-1:0] stop_y;
    logic signed [POS_W-1:0] stop_z;
    outcome_e                outcome;
  } out_t;

  typedef logic [2:0][POS_W-1:0] pos3_t;

  typedef struct packed {
    pos3_t                  pos;
    logic [2:0][RMAG_W-1:0] rmag;
    logic [2:0]             rneg;
    logic                   bad;
    logic                   slow;
  } sq_side_t;

  typedef struct packed {
    pos3_t      pos;
    logic [2:0] rneg;
    logic       bad;
    logic       slow;
  } dv_side_t;

endpackage

`default_nettype wire

>>> src/spp_rotate.sv
// Five-stage quaternion rotation of the body velocity and sum of squares.
`timescale 1ns / 1ps
`default_nettype none

module spp_rotate import spp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  in_t                 data_i,
  input  logic                bad_i,
  output logic                valid_o,
  output logic [SUMSQ_W-1:0]  sumsq_o,
  output sq_side_t            side_o
);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd134217728);

  logic a_v_q, b_v_q, c_v_q, d_v_q, e_v_q;

  // stage A: q x v
  logic signed [C_W-1:0]    qe [3];
  logic signed [C_W-1:0]    ve [3];
  logic signed [C_W-1:0]    c_d [3];
  logic signed [C_W-1:0]    c_q [3];
  logic signed [QUAT_W-1:0] qa_q [3];
  logic signed [QUAT_W-1:0] wa_q;
  logic signed [VEL_W-1:0]  va_q [3];
  pos3_t                    pa_q;
  logic                     bada_q;

  // stage B: second cross product and w terms
  logic signed [P2_W-1:0]   qp [3];
  logic signed [P2_W-1:0]   cp [3];
  logic signed [P2_W-1:0]   wp;
  logic signed [P2_W-1:0]   m1_d [3];
  logic signed [P2_W-1:0]   m2_d [3];
  logic signed [P2_W-1:0]   wc_d [3];
  logic signed [P2_W-1:0]   m1_q [3];
  logic signed [P2_W-1:0]   m2_q [3];
  logic signed [P2_W-1:0]   wc_q [3];
  logic signed [VEL_W-1:0]  vb_q [3];
  pos3_t                    pb_q;
  logic                     badb_q;

  // stage C: sum and round
  logic signed [ACC_W-1:0]  acc [3];
  logic signed [R_W-1:0]    r_d [3];
  logic signed [R_W-1:0]    r_q [3];
  pos3_t                    pc_q;
  logic                     badc_q;

  // stage D: squares
  logic signed [R_W-1:0]    rabs [3];
  logic [RMAG_W-1:0]        rmag_d [3];
  logic [SUMSQ_W-1:0]       sq_d [3];
  logic [SUMSQ_W-1:0]       sq_q [3];
  sq_side_t                 sd_q;

  // stage E: sum of squares
  logic [SUMSQ_W-1:0]       sum_d;
  logic [SUMSQ_W-1:0]       sum_q;
  sq_side_t                 se_q;

  always_comb begin
    qe[0] = C_W'($signed(data_i.quat_x));
    qe[1] = C_W'($signed(data_i.quat_y));
    qe[2] = C_W'($signed(data_i.quat_z));
    ve[0] = C_W'($signed(data_i.vel_fwd));
    ve[1] = C_W'($signed(data_i.vel_side));
    ve[2] = C_W'($signed(data_i.vel_up));
    c_d[0] = qe[1] * ve[2] - qe[2] * ve[1];
    c_d[1] = qe[2] * ve[0] - qe[0] * ve[2];
    c_d[2] = qe[0] * ve[1] - qe[1] * ve[0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qp[i] = P2_W'(qa_q[i]);
      cp[i] = P2_W'(c_q[i]);
    end
    wp = P2_W'(wa_q);
    m1_d[0] = qp[1] * cp[2];
    m2_d[0] = qp[2] * cp[1];
    m1_d[1] = qp[2] * cp[0];
    m2_d[1] = qp[0] * cp[2];
    m1_d[2] = qp[0] * cp[1];
    m2_d[2] = qp[1] * cp[0];
    for (int i = 0; i < 3; i++) begin
      wc_d[i] = wp * cp[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = (ACC_W'(vb_q[i]) <<< FRAC_SH) + (ACC_W'(wc_q[i]) <<< 1)
             + ((ACC_W'(m1_q[i]) - ACC_W'(m2_q[i])) <<< 1);
      r_d[i] = R_W'((acc[i] + ROUND_HALF) >>> FRAC_SH);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rabs[i]   = r_q[i][R_W-1] ? -r_q[i] : r_q[i];
      rmag_d[i] = RMAG_W'(rabs[i]);
      sq_d[i]   = SUMSQ_W'(rmag_d[i]) * SUMSQ_W'(rmag_d[i]);
    end
    sum_d = sq_q[0] + sq_q[1] + sq_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q     <= c_d;
      qa_q[0] <= data_i.quat_x;
      qa_q[1] <= data_i.quat_y;
      qa_q[2] <= data_i.quat_z;
      wa_q    <= data_i.quat_w;
      va_q[0] <= data_i.vel_fwd;
      va_q[1] <= data_i.vel_side;
      va_q[2] <= data_i.vel_up;
      pa_q[0] <= data_i.pos_x;
      pa_q[1] <= data_i.pos_y;
      pa_q[2] <= data_i.pos_z;
      bada_q  <= bad_i;

      m1_q   <= m1_d;
      m2_q   <= m2_d;
      wc_q   <= wc_d;
      vb_q   <= va_q;
      pb_q   <= pa_q;
      badb_q <= bada_q;

      r_q    <= r_d;
      pc_q   <= pb_q;
      badc_q <= badb_q;

      sq_q    <= sq_d;
      sd_q.pos  <= pc_q;
      sd_q.bad  <= badc_q;
      sd_q.slow <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sd_q.rmag[i] <= rmag_d[i];
        sd_q.rneg[i] <= r_q[i][R_W-1];
      end

      sum_q     <= sum_d;
      se_q.pos  <= sd_q.pos;
      se_q.rmag <= sd_q.rmag;
      se_q.rneg <= sd_q.rneg;
      se_q.bad  <= sd_q.bad;
      se_q.slow <= (sum_d <= SLOW_SUMSQ_MAX);
    end
  end

  assign valid_o = e_v_q;
  assign sumsq_o = sum_q;
  assign side_o  = se_q;

endmodule

`default_nettype wire

>>> src/spp_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module spp_sqrt import spp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [SUMSQ_W-1:0]  sumsq_i,
  input  sq_side_t            side_i,
  output logic                valid_o,
  output logic [ROOT_W-1:0]   root_o,
  output sq_side_t            side_o
);

  logic               v_q    [ROOT_W];
  logic [SUMSQ_W-1:0] rad_q  [ROOT_W];
  logic [REM_W-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0]  root_q [ROOT_W];
  sq_side_t           side_q [ROOT_W];

  logic [SUMSQ_W-1:0] rad_in  [ROOT_W];
  logic [REM_W-1:0]   rem_in  [ROOT_W];
  logic [ROOT_W-1:0]  root_in [ROOT_W];
  logic [REM_W-1:0]   rem_sh  [ROOT_W];
  logic [REM_W-1:0]   trial   [ROOT_W];
  logic               ge      [ROOT_W];
  logic [SUMSQ_W-1:0] rad_d   [ROOT_W];
  logic [REM_W-1:0]   rem_d   [ROOT_W];
  logic [ROOT_W-1:0]  root_d  [ROOT_W];

  always_comb begin
    rad_in[0]  = sumsq_i;
    rem_in[0]  = '0;
    root_in[0] = '0;
    for (int k = 1; k < ROOT_W; k++) begin
      rad_in[k]  = rad_q[k-1];
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
    end
    // bring down two radicand bits, try (root << 2) | 1
    for (int k = 0; k < ROOT_W; k++) begin
      rem_sh[k] = {rem_in[k][REM_W-3:0], rad_in[k][SUMSQ_W-1 -: 2]};
      trial[k]  = {root_in[k], 2'b01};
      ge[k]     = (rem_sh[k] >= trial[k]);
      rem_d[k]  = ge[k] ? rem_sh[k] - trial[k] : rem_sh[k];
      root_d[k] = {root_in[k][ROOT_W-2:0], ge[k]};
      rad_d[k]  = {rad_in[k][SUMSQ_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ROOT_W; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < ROOT_W; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < ROOT_W; k++) begin
        side_q[k] <= side_q[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
        rad_q[k]  <= rad_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

`default_nettype wire

>>> src/spp_divide.sv
// Three-lane pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module spp_divide import spp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [2:0][DIVD_W-1:0]  dividend_i,
  input  logic [DEN_W-1:0]        den_i,
  input  dv_side_t                side_i,
  output logic                    valid_o,
  output logic [2:0][DIVD_W-1:0]  quot_o,
  output dv_side_t                side_o
);

  logic                    v_q    [DIVD_W];
  logic [2:0][DIVD_W-1:0]  dq_q   [DIVD_W];
  logic [2:0][DEN_W-1:0]   rem_q  [DIVD_W];
  dv_side_t                side_q [DIVD_W];

  logic [2:0][DIVD_W-1:0]  dq_in  [DIVD_W];
  logic [2:0][DEN_W-1:0]   rem_in [DIVD_W];
  logic [2:0][DEN_W:0]     rem_sh [DIVD_W];
  logic [2:0]              ge     [DIVD_W];
  logic [2:0][DIVD_W-1:0]  dq_d   [DIVD_W];
  logic [2:0][DEN_W-1:0]   rem_d  [DIVD_W];

  always_comb begin
    dq_in[0]  = dividend_i;
    rem_in[0] = '0;
    for (int s = 1; s < DIVD_W; s++) begin
      dq_in[s]  = dq_q[s-1];
      rem_in[s] = rem_q[s-1];
    end
    // shift the next dividend bit in; quotient bits fill from the bottom
    for (int s = 0; s < DIVD_W; s++) begin
      for (int l = 0; l < 3; l++) begin
        rem_sh[s][l] = {rem_in[s][l], dq_in[s][l][DIVD_W-1]};
        ge[s][l]     = (rem_sh[s][l] >= {1'b0, den_i});
        rem_d[s][l]  = ge[s][l] ? DEN_W'(rem_sh[s][l] - {1'b0, den_i})
                                : DEN_W'(rem_sh[s][l]);
        dq_d[s][l]   = {dq_in[s][l][DIVD_W-2:0], ge[s][l]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIVD_W; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < DIVD_W; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < DIVD_W; s++) begin
        side_q[s] <= side_q[s-1];
      end
      for (int s = 0; s < DIVD_W; s++) begin
        dq_q[s]  <= dq_d[s];
        rem_q[s] <= rem_d[s];
      end
    end
  end

  assign valid_o = v_q[DIVD_W-1];
  assign quot_o  = dq_q[DIVD_W-1];
  assign side_o  = side_q[DIVD_W-1];

endmodule

`default_nettype wire

>>> src/stopping_point_projector.sv
// Top level of the stopping point projector.
`timescale 1ns / 1ps
`default_nettype none

// Projects a pose forward by its constant-deceleration stopping distance.
// One transaction is accepted per cycle while in_stall_o is low, and each
// one gives exactly one result, after the rotation and sum-of-squares
// stages, 31 square-root stages, a register for the |r| * speed products,
// 62 divider stages (one quotient bit each, the bulk of the pipeline) and
// the output register. A skid register behind the output keeps the input
// open while one result waits; in_stall_o rises only once both hold a
// result. Write deceleration only while no transaction is in flight.

module stopping_point_projector import spp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic signed [DEC_W-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_t                     in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_t                    out_data_o
);

  logic signed [DEC_W-1:0] decel_q;
  logic [DEC_W-1:0]        dec_mag;
  logic [DEN_W-1:0]        den;
  logic                    pipe_en;

  logic                    rot_v;
  logic [SUMSQ_W-1:0]      rot_sumsq;
  sq_side_t                rot_side;

  logic                    sq_v;
  logic [ROOT_W-1:0]       sq_root;
  sq_side_t                sq_side;

  logic                    n_v_q;
  logic [2:0][DIVD_W-1:0]  divd_d;
  logic [2:0][DIVD_W-1:0]  divd_q;
  dv_side_t                n_side_q;

  logic                    dv_v;
  logic [2:0][DIVD_W-1:0]  dv_quot;
  dv_side_t                dv_side;

  logic signed [SUM_W-1:0] pe [3];
  logic signed [SUM_W-1:0] de [3];
  logic signed [SUM_W-1:0] np [3];
  logic [2:0][POS_W-1:0]   stop;
  logic                    sat;
  out_t                    fin;

  logic                    out_v_q, skid_v_q;
  out_t                    out_q, skid_q;
  logic                    take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decel_q <= '0;
    end else if (cfg_we_i) begin
      decel_q <= cfg_wdata_i;
    end
  end

  assign dec_mag    = DEC_W'(-decel_q);
  assign den        = {dec_mag, 1'b0};
  assign pipe_en    = !skid_v_q;
  assign in_stall_o = skid_v_q;

  spp_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .bad_i   (!decel_q[DEC_W-1]),
    .valid_o (rot_v),
    .sumsq_o (rot_sumsq),
    .side_o  (rot_side)
  );

  spp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (rot_v),
    .sumsq_i (rot_sumsq),
    .side_i  (rot_side),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // numerator plus half the divisor gives round-half-up on the magnitude
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      divd_d[l] = DIVD_W'(sq_side.rmag[l]) * DIVD_W'(sq_root) + DIVD_W'(dec_mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_v_q <= 1'b0;
    end else if (pipe_en) begin
      n_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      divd_q        <= divd_d;
      n_side_q.pos  <= sq_side.pos;
      n_side_q.rneg <= sq_side.rneg;
      n_side_q.bad  <= sq_side.bad;
      n_side_q.slow <= sq_side.slow;
    end
  end

  spp_divide u_divide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .valid_i    (n_v_q),
    .dividend_i (divd_q),
    .den_i      (den),
    .side_i     (n_side_q),
    .valid_o    (dv_v),
    .quot_o     (dv_quot),
    .side_o     (dv_side)
  );

  always_comb begin
    sat = 1'b0;
    for (int l = 0; l < 3; l++) begin
      pe[l] = SUM_W'($signed(dv_side.pos[l]));
      de[l] = $signed({2'b00, dv_quot[l]});
      np[l] = dv_side.rneg[l] ? pe[l] - de[l] : pe[l] + de[l];
      if (np[l] > POS_MAX_S) begin
        stop[l] = POS_W'(POS_MAX_S);
        sat     = 1'b1;
      end else if (np[l] < POS_MIN_S) begin
        stop[l] = POS_W'(POS_MIN_S);
        sat     = 1'b1;
      end else begin
        stop[l] = POS_W'(np[l]);
      end
    end
    if (dv_side.bad || dv_side.slow) begin
      stop = dv_side.pos;
    end
    fin.stop_x = stop[0];
    fin.stop_y = stop[1];
    fin.stop_z = stop[2];
    if (dv_side.bad) begin
      fin.outcome = OUT_BAD_DECEL;
    end else if (dv_side.slow) begin
      fin.outcome = OUT_TOO_SLOW;
    end else if (sat) begin
      fin.outcome = OUT_SATURATED;
    end else begin
      fin.outcome = OUT_PROJECTED;
    end
  end

  assign take = out_v_q && !out_stall_i;

  // output register with skid: park a result when the output is held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pipe_en && dv_v) begin
      if (out_v_q && !take) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (take) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && dv_v) begin
      if (out_v_q && !take) begin
        skid_q <= fin;
      end else begin
        out_q <= fin;
      end
    end else if (take && skid_v_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> src/spp_checker.sv
// Port-level checker for the stopping point projector, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
`include "stopping_point_projector_defines.svh"

module spp_checker import spp_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input out_t                    out_data_o
);

  `SPP_ASSERT(a_out_valid_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")
  `SPP_ASSERT(a_out_data_hold, out_valid_o && out_stall_i |=> $stable(out_data_o), "result moved")
  `SPP_ASSERT(a_stall_needs_out, in_stall_o |-> out_valid_o, "skid full, output empty")
  `SPP_ASSERT(a_stall_cause, in_stall_o |-> $past(out_valid_o && out_stall_i), "stall unprovoked")
  `SPP_ASSERT_RST(a_reset_idle, !rst_ni |-> !out_valid_o && !in_stall_o, "busy in reset")

endmodule

bind stopping_point_projector spp_checker u_spp_checker (.*);

`default_nettype wire
